[hw/rtl/phbf_pkg.sv]
// Package for the prefix hash bloom filter.
// Holds the filter size, hash constants and derived widths; no dependencies.
`timescale 1ns / 1ps

package phbf_pkg;

  localparam int FILTER_BITS = 459983;
  localparam int PREFIX_LEN  = 7;

  localparam int ACC_W  = 64;
  localparam int CHAR_W = 7;
  localparam int POS_W  = 3;
  localparam int MUL_W  = 25;
  localparam int HALF_W = ACC_W / 2;

  localparam logic [MUL_W-1:0] HASH_MUL = MUL_W'(27644437);
  localparam logic [ACC_W-1:0] HASH_ADD = ACC_W'(115249);

  // remainder of the hash; it always lies below FILTER_BITS
  localparam int IDX_W     = $clog2(FILTER_BITS);
  localparam int OUT_IDX_W = 19;

  // filter store is kept as rows of ROW_W bits
  localparam int ROW_W     = 64;
  localparam int BIT_W     = $clog2(ROW_W);
  localparam int ROWS      = (FILTER_BITS + ROW_W - 1) / ROW_W;
  localparam int ADDR_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_EXT_W = ADDR_W + BIT_W;

  // modulo: each hash byte weighted by 2^(8i) mod FILTER_BITS, then summed
  localparam int FOLD_BYTES = ACC_W / 8;
  localparam logic [FOLD_BYTES-1:0][IDX_W-1:0] BYTE_RES = {
    IDX_W'((64'd1 << 56) % FILTER_BITS),
    IDX_W'((64'd1 << 48) % FILTER_BITS),
    IDX_W'((64'd1 << 40) % FILTER_BITS),
    IDX_W'((64'd1 << 32) % FILTER_BITS),
    IDX_W'((64'd1 << 24) % FILTER_BITS),
    IDX_W'((64'd1 << 16) % FILTER_BITS),
    IDX_W'((64'd1 << 8) % FILTER_BITS),
    IDX_W'((64'd1 << 0) % FILTER_BITS)
  };
  localparam int FOLD_W =
    $clog2(longint'(FOLD_BYTES) * 255 * longint'(FILTER_BITS - 1) + 1);

  // quotient of the folded sum by reciprocal multiply; at most one too low
  localparam int                RECIP_SHIFT = 48;
  localparam longint unsigned   RECIP_FULL  = (64'd1 << RECIP_SHIFT) / FILTER_BITS;
  localparam int                RECIP_W     = $clog2(RECIP_FULL + 1);
  localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_FULL);
  localparam int                PROD_W      = FOLD_W + RECIP_W;
  localparam int QUOT_W = $clog2(((64'd1 << FOLD_W) - 1) / FILTER_BITS + 1);

endpackage

[hw/rtl/prefix_hash_bloom_filter_top.sv]
// Prefix hash bloom filter, top level.
// Uses phbf_pkg for sizes and hash constants.
// A prefix character is accepted, then runs a three-step multiply-add on
// a 32x25 multiplier; a character past the prefix is only accepted.
// A last character then runs the modulo (byte fold, reciprocal quotient,
// subtract, correction), a store read and a check/write; its result is
// registered in check/write, and the next item can be taken in the cycle
// after at the earliest; a full output register holds the block in
// check/write until out_tready.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to
// every store row, during which no item is taken.
`timescale 1ns / 1ps

module prefix_hash_bloom_filter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [6:0] char_code, [7] zero
  input  logic        in_tlast,   // word_end
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [0] hit, [19:1] bit_index, [23:20] zero
);
  import phbf_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_ACC,
    S_FOLD,
    S_QUOT,
    S_SUB,
    S_FIX,
    S_READ,
    S_CHECK
  } state_t;

  state_t                  state_r;
  logic [POS_W-1:0]        pos_r;
  logic [ACC_W-1:0]        acc_r;
  logic [ACC_W-1:0]        sum_r;
  logic [HALF_W+MUL_W-1:0] p_lo_r;
  logic [HALF_W-1:0]       p_hi_r;
  logic [ACC_W-1:0]        lo_sum_r;
  logic                    last_r;
  logic                    cmd_r;
  logic [FOLD_W-1:0]       fold_r;
  logic [QUOT_W-1:0]       quot_r;
  logic [IDX_W:0]          part_r;
  logic [IDX_W-1:0]        rem_r;
  logic [ADDR_W-1:0]       clr_row_r;
  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [OUT_IDX_W-1:0]    out_idx_r;

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROW_W-1:0] rd_data_r;

  logic              accept;
  logic              hashing;
  logic [ACC_W-1:0]  acc_nxt;
  logic [FOLD_W-1:0] fold_sum;
  logic [PROD_W-1:0] recip_prod;
  logic              part_ge;
  logic [IDX_EXT_W-1:0] idx_ext;
  logic [ADDR_W-1:0] row;
  logic [BIT_W-1:0]  bitpos;
  logic              out_free;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;
  logic              mem_re;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign hashing    = (pos_r < POS_W'(PREFIX_LEN));
  assign acc_nxt    = lo_sum_r + {p_hi_r, {HALF_W{1'b0}}};
  assign recip_prod = PROD_W'(fold_r) * PROD_W'(RECIP);
  assign part_ge    = (part_r >= (IDX_W+1)'(FILTER_BITS));
  assign idx_ext    = IDX_EXT_W'(rem_r);
  assign row        = idx_ext[IDX_EXT_W-1:BIT_W];
  assign bitpos     = idx_ext[BIT_W-1:0];
  assign out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_idx_r, out_hit_r};

  // hash congruent mod FILTER_BITS, small enough for the reciprocal step
  always_comb begin
    fold_sum = '0;
    for (int i = 0; i < FOLD_BYTES; i++) begin
      fold_sum = fold_sum + FOLD_W'(acc_r[8*i +: 8]) * FOLD_W'(BYTE_RES[i]);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row;
    mem_wdata = rd_data_r | (ROW_W'(1) << bitpos);
    mem_re    = (state_r == S_READ);
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_row_r;
      mem_wdata = '0;
    end else if (state_r == S_CHECK && out_free && cmd_r) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[row];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pos_r       <= '0;
      acc_r       <= '0;
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_CHECK && out_free) out_valid_r <= 1'b1;
      else if (out_tready)                out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_row_r <= clr_row_r + ADDR_W'(1);
          if (clr_row_r == ADDR_W'(ROWS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            last_r <= in_tlast;
            cmd_r  <= in_tuser;
            sum_r  <= acc_r + ACC_W'(in_tdata[CHAR_W-1:0]);
            if (hashing) begin
              pos_r   <= pos_r + POS_W'(1);
              state_r <= S_MUL_LO;
            end else if (in_tlast) begin
              state_r <= S_FOLD;
            end
          end
        end
        S_MUL_LO: begin
          p_lo_r  <= sum_r[HALF_W-1:0] * HASH_MUL;
          state_r <= S_MUL_HI;
        end
        S_MUL_HI: begin
          // only the low half of the upper product survives mod 2^64
          p_hi_r   <= HALF_W'(sum_r[ACC_W-1:HALF_W] * HASH_MUL);
          lo_sum_r <= ACC_W'(p_lo_r) + HASH_ADD;
          state_r  <= S_ACC;
        end
        S_ACC: begin
          acc_r <= acc_nxt;
          if (last_r) state_r <= S_FOLD;
          else        state_r <= S_IDLE;
        end
        S_FOLD: begin
          fold_r  <= fold_sum;
          acc_r   <= '0;
          pos_r   <= '0;
          state_r <= S_QUOT;
        end
        S_QUOT: begin
          quot_r  <= recip_prod[RECIP_SHIFT +: QUOT_W];
          state_r <= S_SUB;
        end
        S_SUB: begin
          // quotient may be one low, so this lies below 2*FILTER_BITS
          part_r  <= (IDX_W+1)'(fold_r - FOLD_W'(quot_r) * FOLD_W'(FILTER_BITS));
          state_r <= S_FIX;
        end
        S_FIX: begin
          if (part_ge) rem_r <= IDX_W'(part_r - (IDX_W+1)'(FILTER_BITS));
          else         rem_r <= part_r[IDX_W-1:0];
          state_r <= S_READ;
        end
        S_READ: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          // hold the row until the output register is free
          if (out_free) begin
            out_hit_r <= rd_data_r[bitpos];
            out_idx_r <= OUT_IDX_W'(rem_r);
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[test/prefix_hash_bloom_filter_top_tb.sv]
// Self-checking testbench for prefix_hash_bloom_filter_top.
// Streams words item by item and checks hit/bit_index against its own filter
// shadow under varied stream idling; depends on phbf_pkg.
`timescale 1ns / 1ps

module prefix_hash_bloom_filter_top_tb;
  import phbf_pkg::*;

  localparam bit CMD_TEST   = 1'b0;
  localparam bit CMD_INSERT = 1'b1;

  localparam int RANDOM_ITEMS = 1330;
  localparam int MAX_WORD_LEN = 12;
  localparam int LONG_HOLD    = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int BANK_DEPTH   = 64;

  localparam logic [ACC_W-1:0] FILTER_MOD = ACC_W'(FILTER_BITS);

  // idling per phase, percent of cycles
  localparam int SEND_IDLE [4]  = '{0, 47, 0, 18};
  localparam int RECV_STALL [4] = '{0, 0, 47, 18};

  typedef struct {
    bit                 hit;
    bit [OUT_IDX_W-1:0] bit_index;
  } lookup_t;

  typedef struct {
    bit       cmd;
    bit [6:0] ch;
    bit       last;
    bit       pad;
    bit       hit_known;
    bit       hit_val;
  } stim_row_t;

  typedef struct {
    bit [6:0] chars [MAX_WORD_LEN];
    int       len;
    bit       cmd;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [6:0] char_code, [7] zero
  logic        in_tlast = 1'b0; // word_end
  logic        in_tuser = 1'b0; // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [0] hit, [19:1] bit_index, [23:20] zero

  // shadow of the block's state
  logic [ACC_W-1:0] word_hash = '0;
  int               hashed_chars = 0;
  bit               filter_shadow [int unsigned];
  lookup_t          pending_lookups [$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  fail_count = 0;
  int  random_items = 0;

  stim_row_t directed_rows [$];
  word_t     word_bank [$];

  prefix_hash_bloom_filter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    lookup_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_lookups.size() == 0) begin
        $error("unexpected result: tdata %h", out_tdata);
        fail_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (out_tdata[0] !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[19:1] !== want.bit_index) begin
          $error("bit_index: expected %0d, actual %0d", want.bit_index, out_tdata[19:1]);
          fail_count++;
        end
      end
    end
  end

  // Update the shadow for one accepted item; a last character queues a lookup.
  task automatic absorb_item(input bit cmd, input bit [6:0] ch, input bit last,
                             input bit hit_known, input bit hit_val);
    logic [ACC_W-1:0] idx;
    lookup_t          res;
    if (hashed_chars < PREFIX_LEN) begin
      word_hash = (word_hash + ACC_W'(ch)) * ACC_W'(HASH_MUL) + HASH_ADD;
      hashed_chars++;
    end
    if (last) begin
      idx = word_hash % FILTER_MOD;
      res.hit = filter_shadow.exists(int'(idx));
      res.bit_index = idx[OUT_IDX_W-1:0];
      if (hit_known) res.hit = hit_val;
      if (cmd == CMD_INSERT) filter_shadow[int'(idx)] = 1'b1;
      pending_lookups.insert(pending_lookups.size(), res);
      word_hash = '0;
      hashed_chars = 0;
    end
  endtask

  task automatic send_item(input bit cmd, input bit [6:0] ch, input bit last, input bit pad,
                           input bit hit_known, input bit hit_val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pad, ch};
    in_tlast  <= last;
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_item(cmd, ch, last, hit_known, hit_val);
  endtask

  task automatic send_word(input word_t w);
    bit last;
    for (int i = 0; i < w.len; i++) begin
      last = (i == w.len - 1);
      // cmd on inner characters is don't-care, so randomize it
      send_item(last ? w.cmd : bit'($urandom_range(1)), w.chars[i], last,
                ($urandom_range(7) == 0), 1'b0, 1'b0);
      random_items++;
    end
  endtask

  function automatic word_t fresh_word();
    word_t w;
    int    r;
    r = $urandom_range(99);
    if (r < 10) w.len = 1;
    else if (r < 80) w.len = $urandom_range(PREFIX_LEN, 2);
    else w.len = $urandom_range(MAX_WORD_LEN, PREFIX_LEN + 1);
    for (int i = 0; i < MAX_WORD_LEN; i++)
      w.chars[i] = $urandom_range(1) ? 7'($urandom_range(127)) : 7'($urandom_range(8'h7a, 8'h61));
    w.cmd = 1'($urandom_range(1));
    return w;
  endfunction

  // reuse an earlier inserted word, sometimes with a different tail past the prefix
  function automatic word_t replay_word();
    word_t w;
    w = word_bank[$urandom_range(word_bank.size() - 1)];
    if (w.len >= PREFIX_LEN && $urandom_range(1)) begin
      w.len = $urandom_range(MAX_WORD_LEN, PREFIX_LEN);
      for (int i = PREFIX_LEN; i < MAX_WORD_LEN; i++) w.chars[i] = 7'($urandom_range(127));
    end
    w.cmd = 1'($urandom_range(1));
    return w;
  endfunction

  initial begin : stimulus
    word_t w;
    int    phase;
    bit    hold_done;
    hold_done = 1'b0;

    // cmd, ch, last, pad, hit_known, hit
    directed_rows = '{
      // empty store after reset
      '{CMD_TEST,   7'h61, 1'b1, 1'b0, 1'b1, 1'b0},
      '{CMD_INSERT, 7'h00, 1'b1, 1'b0, 1'b1, 1'b0},
      '{CMD_TEST,   7'h00, 1'b1, 1'b0, 1'b1, 1'b1},
      '{CMD_INSERT, 7'h7f, 1'b1, 1'b0, 1'b0, 1'b0},
      // nine characters, cmd mixed on inner ones, inserted
      '{CMD_INSERT, 7'h7f, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_TEST,   7'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_INSERT, 7'h55, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_INSERT, 7'h2a, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_TEST,   7'h01, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_INSERT, 7'h40, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_INSERT, 7'h7e, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_INSERT, 7'h33, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_INSERT, 7'h12, 1'b1, 1'b0, 1'b0, 1'b0},
      // same prefix, different tail, stray high tdata bit: must hit
      '{CMD_INSERT, 7'h7f, 1'b0, 1'b1, 1'b0, 1'b0},
      '{CMD_TEST,   7'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_INSERT, 7'h55, 1'b0, 1'b1, 1'b0, 1'b0},
      '{CMD_TEST,   7'h2a, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_INSERT, 7'h01, 1'b0, 1'b1, 1'b0, 1'b0},
      '{CMD_TEST,   7'h40, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_TEST,   7'h7e, 1'b0, 1'b1, 1'b0, 1'b0},
      '{CMD_TEST,   7'h6c, 1'b1, 1'b1, 1'b1, 1'b1}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].ch, directed_rows[i].last,
                directed_rows[i].pad, directed_rows[i].hit_known, directed_rows[i].hit_val);

    while (random_items < RANDOM_ITEMS) begin
      phase = random_items * 4 / RANDOM_ITEMS;
      send_idle_pct = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      if (!hold_done && random_items >= 60) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (word_bank.size() != 0 && $urandom_range(99) < 40) w = replay_word();
      else w = fresh_word();
      send_word(w);
      if (w.cmd == CMD_INSERT) begin
        word_bank.insert(word_bank.size(), w);
        if (word_bank.size() > BANK_DEPTH) void'(word_bank.pop_front());
      end
    end
    in_tvalid <= 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
